// File: rtl/rwab_pkg.sv
// Shared types, constants and helper functions for the weighted RGBA alpha blend.
// Used by every module of the block; depends on nothing else.

package rwab_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned NumW         = 25;
  localparam int unsigned DenW         = 17;
  localparam int unsigned QuoW         = 8;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned NumDivStage  = QuoW / BitsPerStage;
  localparam logic [ChanW-1:0] FullScale = 8'd255;

  typedef enum logic [1:0] {
    ModeStraight  = 2'd0,
    ModePremul    = 2'd1,
    ModeViaPremul = 2'd2
  } mode_e;

  // Products and raw channels after the first register.
  typedef struct packed {
    mode_e                  mode;
    logic [3:0][ChanW-1:0]  a;
    logic [3:0][ChanW-1:0]  b;
    logic [ChanW-1:0]       wa;
    logic [ChanW-1:0]       wb;
    logic [2:0][15:0]       pra;
    logic [2:0][15:0]       prb;
    logic [15:0]            fa;
    logic [15:0]            fb;
  } s1_t;

  // Channels, premultiplied where the mode asks for it.
  typedef struct packed {
    mode_e                  mode;
    logic [3:0][ChanW-1:0]  pa;
    logic [3:0][ChanW-1:0]  pb;
    logic [ChanW-1:0]       wa;
    logic [ChanW-1:0]       wb;
    logic [15:0]            fa;
    logic [15:0]            fb;
  } s2_t;

  // Weighted sums per lane; lane 3 holds the combined alpha in straight mode.
  typedef struct packed {
    mode_e                  mode;
    logic [3:0][NumW-1:0]   sum;
  } s3_t;

  // Sums scaled down by full scale and saturated.
  typedef struct packed {
    mode_e                  mode;
    logic [3:0][ChanW-1:0]  m;
    logic                   clip;
    logic [3:0][NumW-1:0]   sum;
  } s4_t;

  // Payload of the restoring divider pipeline, three color lanes.
  typedef struct packed {
    logic [2:0][NumW-1:0]   rem;
    logic [DenW-1:0]        den;
    logic [2:0][QuoW-1:0]   quo;
    logic [2:0]             ovf;
    logic [ChanW-1:0]       alpha;
    logic                   clip;
    logic                   zero;
  } div_t;

  // Exact floor(n / 255): reciprocal estimate, which is high by at most one,
  // followed by a single correction.
  function automatic logic [10:0] div255(input logic [17:0] n);
    logic [33:0] t;
    logic [10:0] est;
    logic [18:0] prod;
    t    = (34'(n) << 15) + (34'(n) << 7) + 34'(n);
    est  = t[33:23];
    prod = (19'(est) << 8) - 19'(est);
    if (prod > 19'(n)) begin
      est = est - 11'd1;
    end
    return est;
  endfunction

endpackage

// File: rtl/rwab_blend.sv
// Front of the blend pipeline: weight products, premultiply, weighted sums,
// scaling by full scale and set-up of the divider operands. Uses rwab_pkg.

module rwab_blend (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  rwab_pkg::mode_e                 mode_i,
  input  logic [3:0][rwab_pkg::ChanW-1:0] a_i,
  input  logic [3:0][rwab_pkg::ChanW-1:0] b_i,
  input  logic [rwab_pkg::ChanW-1:0]      wa_i,
  input  logic [rwab_pkg::ChanW-1:0]      wb_i,
  output logic                            div_valid_o,
  output rwab_pkg::div_t                  div_o
);

  rwab_pkg::s1_t  s1_d, s1_q;
  rwab_pkg::s2_t  s2_d, s2_q;
  rwab_pkg::s3_t  s3_d, s3_q;
  rwab_pkg::s4_t  s4_d, s4_q;
  rwab_pkg::div_t s5_d, s5_q;
  logic [4:0]     vld_q;

  // Stage 1: all 8x8 products that the three paths need.
  always_comb begin
    s1_d.mode = mode_i;
    s1_d.a    = a_i;
    s1_d.b    = b_i;
    s1_d.wa   = wa_i;
    s1_d.wb   = wb_i;
    s1_d.fa   = 16'(a_i[3]) * 16'(wa_i);
    s1_d.fb   = 16'(b_i[3]) * 16'(wb_i);
    for (int i = 0; i < 3; i++) begin
      s1_d.pra[i] = 16'(a_i[i]) * 16'(a_i[3]);
      s1_d.prb[i] = 16'(b_i[i]) * 16'(b_i[3]);
    end
  end

  // Stage 2: premultiply colors in the via-premultiply mode.
  always_comb begin
    logic [10:0] qa;
    logic [10:0] qb;
    s2_d.mode  = s1_q.mode;
    s2_d.wa    = s1_q.wa;
    s2_d.wb    = s1_q.wb;
    s2_d.fa    = s1_q.fa;
    s2_d.fb    = s1_q.fb;
    s2_d.pa    = s1_q.a;
    s2_d.pb    = s1_q.b;
    for (int i = 0; i < 3; i++) begin
      qa = rwab_pkg::div255(18'(s1_q.pra[i]));
      qb = rwab_pkg::div255(18'(s1_q.prb[i]));
      if (s1_q.mode == rwab_pkg::ModeViaPremul) begin
        s2_d.pa[i] = qa[7:0];
        s2_d.pb[i] = qb[7:0];
      end
    end
  end

  // Stage 3: weighted sums. Straight mode weights colors by the scaled alphas.
  always_comb begin
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    s3_d.mode = s2_q.mode;
    if (s2_q.mode == rwab_pkg::ModeStraight) begin
      mul_a = s2_q.fa;
      mul_b = s2_q.fb;
    end else begin
      mul_a = 16'(s2_q.wa);
      mul_b = 16'(s2_q.wb);
    end
    for (int i = 0; i < 4; i++) begin
      s3_d.sum[i] = 25'(mul_a) * 25'(s2_q.pa[i]) + 25'(mul_b) * 25'(s2_q.pb[i]);
    end
    if (s2_q.mode == rwab_pkg::ModeStraight) begin
      s3_d.sum[3] = 25'(s2_q.fa) + 25'(s2_q.fb);
    end
  end

  // Stage 4: divide every lane by full scale and saturate. In straight mode
  // only the alpha lane result is used.
  always_comb begin
    logic [10:0] q;
    logic [3:0]  over;
    s4_d.mode = s3_q.mode;
    s4_d.sum  = s3_q.sum;
    for (int i = 0; i < 4; i++) begin
      q       = rwab_pkg::div255(s3_q.sum[i][17:0]);
      over[i] = (q > 11'(rwab_pkg::FullScale));
      s4_d.m[i] = over[i] ? rwab_pkg::FullScale : q[7:0];
    end
    if (s3_q.mode == rwab_pkg::ModeStraight) begin
      s4_d.clip = over[3];
    end else begin
      s4_d.clip = |over;
    end
  end

  // Stage 5: divider operands and the saturation check. The premultiplied
  // path divides by one so that its values ride through unchanged.
  always_comb begin
    logic [2:0][rwab_pkg::NumW-1:0] num;
    num        = '0;
    s5_d.den   = rwab_pkg::DenW'(1);
    s5_d.alpha = s4_q.m[3];
    s5_d.clip  = s4_q.clip;
    s5_d.zero  = 1'b0;
    s5_d.quo   = '0;
    case (s4_q.mode)
      rwab_pkg::ModeStraight: begin
        s5_d.den  = s4_q.sum[3][rwab_pkg::DenW-1:0];
        s5_d.zero = (s4_q.sum[3][rwab_pkg::DenW-1:0] == '0);
        for (int i = 0; i < 3; i++) begin
          num[i] = s4_q.sum[i];
        end
      end
      rwab_pkg::ModePremul: begin
        for (int i = 0; i < 3; i++) begin
          num[i] = 25'(s4_q.m[i]);
        end
      end
      rwab_pkg::ModeViaPremul: begin
        s5_d.den  = 17'(s4_q.m[3]);
        s5_d.zero = (s4_q.m[3] == '0);
        for (int i = 0; i < 3; i++) begin
          num[i] = 25'((16'(s4_q.m[i]) << 8) - 16'(s4_q.m[i]));
        end
      end
      default: begin
        s5_d.zero  = 1'b1;
        s5_d.alpha = '0;
      end
    endcase
    s5_d.rem = num;
    for (int i = 0; i < 3; i++) begin
      s5_d.ovf[i] = (num[i] >= {s5_d.den, 8'h00});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
    s4_q <= s4_d;
    s5_q <= s5_d;
  end

  assign div_valid_o = vld_q[4];
  assign div_o       = s5_q;

endmodule

// File: rtl/rwab_div.sv
// Pipelined restoring divider for the three color lanes, two quotient bits
// per stage. Uses rwab_pkg.

module rwab_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  rwab_pkg::div_t div_i,
  output logic           valid_o,
  output rwab_pkg::div_t div_o
);

  rwab_pkg::div_t                   st_q [rwab_pkg::NumDivStage];
  logic [rwab_pkg::NumDivStage-1:0] vld_q;

  for (genvar s = 0; s < rwab_pkg::NumDivStage; s++) begin : g_stage
    localparam int unsigned Hi = rwab_pkg::QuoW - 1 - s * rwab_pkg::BitsPerStage;
    rwab_pkg::div_t src;
    rwab_pkg::div_t nxt;
    logic           src_v;

    if (s == 0) begin : g_first
      assign src   = div_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[s-1];
      assign src_v = vld_q[s-1];
    end

    // The quotient is known to fit in eight bits unless the overflow flag is
    // set, so each step only tries one shifted divisor.
    always_comb begin
      logic [2:0]                bi;
      logic [rwab_pkg::NumW-1:0] trial;
      nxt = src;
      for (int k = 0; k < rwab_pkg::BitsPerStage; k++) begin
        bi = 3'(Hi - k);
        for (int l = 0; l < 3; l++) begin
          trial = rwab_pkg::NumW'(nxt.den) << bi;
          if (nxt.rem[l] >= trial) begin
            nxt.rem[l]     = nxt.rem[l] - trial;
            nxt.quo[l][bi] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= nxt;
    end
  end

  assign valid_o = vld_q[rwab_pkg::NumDivStage-1];
  assign div_o   = st_q[rwab_pkg::NumDivStage-1];

endmodule

// File: rtl/rgba_weighted_alpha_blend.sv
// Weighted RGBA alpha blend top level: mode register, blend front end and
// divider pipeline. Uses rwab_pkg, rwab_blend and rwab_div.
// A result is strobed on done_o after its start transaction has passed through
// five front-end stages and four divider stages of two quotient bits each.
// Throughput: one transaction per cycle; busy_o never rises since nothing stalls.
// Reset clears the pipeline valid bits and sets the blend mode to straight alpha.

module rgba_weighted_alpha_blend (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] a_red_i,
  input  logic [7:0] a_green_i,
  input  logic [7:0] a_blue_i,
  input  logic [7:0] a_alpha_i,
  input  logic [7:0] b_red_i,
  input  logic [7:0] b_green_i,
  input  logic [7:0] b_blue_i,
  input  logic [7:0] b_alpha_i,
  input  logic [7:0] a_weight_i,
  input  logic [7:0] b_weight_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  output logic       done_o,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o,
  output logic       clipped_o
);

  rwab_pkg::mode_e                 mode_q;
  logic [3:0][rwab_pkg::ChanW-1:0] a_pix;
  logic [3:0][rwab_pkg::ChanW-1:0] b_pix;
  logic                            div_in_v;
  rwab_pkg::div_t                  div_in;
  logic                            res_v;
  rwab_pkg::div_t                  res;
  logic [2:0][rwab_pkg::ChanW-1:0] color;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rwab_pkg::ModeStraight;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= rwab_pkg::mode_e'(cfg_data_i);
    end
  end

  assign a_pix = {a_alpha_i, a_blue_i, a_green_i, a_red_i};
  assign b_pix = {b_alpha_i, b_blue_i, b_green_i, b_red_i};

  rwab_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i && !busy_o),
    .mode_i      (mode_q),
    .a_i         (a_pix),
    .b_i         (b_pix),
    .wa_i        (a_weight_i),
    .wb_i        (b_weight_i),
    .div_valid_o (div_in_v),
    .div_o       (div_in)
  );

  rwab_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_in_v),
    .div_i   (div_in),
    .valid_o (res_v),
    .div_o   (res)
  );

  // A zero divisor, or a mode with no meaning, forces an all-zero pixel.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (res.zero) begin
        color[i] = '0;
      end else if (res.ovf[i]) begin
        color[i] = rwab_pkg::FullScale;
      end else begin
        color[i] = res.quo[i];
      end
    end
  end

  assign done_o      = res_v;
  assign out_red_o   = color[0];
  assign out_green_o = color[1];
  assign out_blue_o  = color[2];
  assign out_alpha_o = res.zero ? '0 : res.alpha;
  assign clipped_o   = !res.zero && (res.clip || (|res.ovf));

endmodule
